// ----- rtl/fma64_pkg.sv -----
// Shared types, constants and helper functions for the binary64 fused multiply-add.
// Used by fused_multiply_add_binary64 and by its testbench.
package fma64_pkg;

  typedef logic [63:0] word_t;
  typedef logic signed [13:0] exp_t;

  typedef struct packed {
    logic [52:0] man;
    exp_t        expo;
  } unpacked_t;

  localparam word_t QUIET_BIT   = 64'h0008_0000_0000_0000;
  localparam word_t INF_BITS    = 64'h7FF0_0000_0000_0000;
  localparam word_t DEFAULT_NAN = 64'h7FF8_0000_0000_0000;
  localparam exp_t  EXP_BIAS    = 14'sd1075;
  localparam exp_t  EXP_MIN     = -14'sd1074;
  localparam exp_t  EXP_INF     = 14'sd2047;
  localparam exp_t  PROD_SHIFT  = 14'sd21;
  localparam exp_t  ADD_SHIFT   = 14'sd74;
  localparam exp_t  LEAD_POS    = 14'sd75;   // 127 - 52
  localparam logic [7:0] SH_SAT = 8'd128;

  // leading zeros of a 53-bit value, 53 when zero
  function automatic logic [5:0] lzc53(input logic [52:0] x);
    logic [5:0] n;
    n = 6'd53;
    for (int i = 0; i < 53; i++) begin
      if (x[i]) n = 6'(52 - i);
    end
    return n;
  endfunction

  // leading zeros of a 128-bit value, 128 when zero
  function automatic logic [7:0] lzc128(input logic [127:0] x);
    logic [7:0] n;
    n = 8'd128;
    for (int i = 0; i < 128; i++) begin
      if (x[i]) n = 8'(127 - i);
    end
    return n;
  endfunction

  // nonzero finite operand -> significand with bit 52 set, LSB exponent
  function automatic unpacked_t unpack(input word_t x);
    unpacked_t  u;
    logic [5:0] lz;
    lz = lzc53({1'b0, x[51:0]});
    if (x[62:52] == 11'd0) begin
      u.man  = {1'b0, x[51:0]} << lz;
      u.expo = EXP_MIN - exp_t'(lz);
    end else begin
      u.man  = {1'b1, x[51:0]};
      u.expo = exp_t'({3'b000, x[62:52]}) - EXP_BIAS;
    end
    return u;
  endfunction

endpackage

// ----- rtl/fused_multiply_add_binary64.sv -----
// Pipelined IEEE-754 binary64 fused multiply-add, round to nearest even.
// Depends on fma64_pkg.

// fused_result = mult_a * mult_b + addend_c, rounded once to nearest/even.
// Eight register stages: decode, partial products, product sum, addend
// alignment, add/subtract, leading-zero count, normalize shift, round/pack.
// A new request can enter every cycle while in_ready is high.
// Each stage holds its own valid bit and
// advances whenever the stage after it has room, so bubbles collapse and
// back-pressure on the output only stalls stages that are full.
// NaNs are quieted (first NaN of a, b, c wins), invalid operations give
// the default quiet NaN, overflow gives signed infinity. No flags.
module fused_multiply_add_binary64 (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  fma64_pkg::word_t  mult_a,
  input  fma64_pkg::word_t  mult_b,
  input  fma64_pkg::word_t  addend_c,
  output logic              out_valid,
  input  logic              out_ready,
  output fma64_pkg::word_t  fused_result
);
  import fma64_pkg::*;

  localparam int NSTAGE = 8;

  logic [NSTAGE:1] vld;
  logic [NSTAGE+1:1] en;

  always_comb begin
    en[NSTAGE+1] = out_ready;
    for (int k = NSTAGE; k >= 1; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign in_ready  = en[1];
  assign out_valid = vld[NSTAGE];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[1]) begin
        vld[1] <= in_valid;
      end
      for (int k = 2; k <= NSTAGE; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // ---------------- stage 1: classify, special cases, unpack
  logic sa, sb, sc, ps;
  logic nan_a, nan_b, nan_c, inf_a, inf_b, inf_c, z_a, z_b, z_c;
  logic spec_d;
  word_t spec_val_d;
  unpacked_t ua, ub, uc;

  always_comb begin
    sa = mult_a[63];
    sb = mult_b[63];
    sc = addend_c[63];
    ps = sa ^ sb;
    nan_a = (mult_a[62:52] == 11'h7FF) && (mult_a[51:0] != '0);
    nan_b = (mult_b[62:52] == 11'h7FF) && (mult_b[51:0] != '0);
    nan_c = (addend_c[62:52] == 11'h7FF) && (addend_c[51:0] != '0);
    inf_a = (mult_a[62:0] == INF_BITS[62:0]);
    inf_b = (mult_b[62:0] == INF_BITS[62:0]);
    inf_c = (addend_c[62:0] == INF_BITS[62:0]);
    z_a = (mult_a[62:0] == '0);
    z_b = (mult_b[62:0] == '0);
    z_c = (addend_c[62:0] == '0);
    spec_d = 1'b1;
    spec_val_d = '0;
    if (nan_a) begin
      spec_val_d = mult_a | QUIET_BIT;
    end else if (nan_b) begin
      spec_val_d = mult_b | QUIET_BIT;
    end else if (nan_c) begin
      spec_val_d = addend_c | QUIET_BIT;
    end else if (inf_a || inf_b) begin
      // inf * 0, or inf - inf, is invalid
      if (z_a || z_b || (inf_c && (sc != ps))) spec_val_d = DEFAULT_NAN;
      else spec_val_d = {ps, INF_BITS[62:0]};
    end else if (inf_c) begin
      spec_val_d = addend_c;
    end else if (z_a || z_b) begin
      spec_val_d = z_c ? {ps & sc, 63'd0} : addend_c;
    end else begin
      spec_d = 1'b0;
    end
    ua = unpack(mult_a);
    ub = unpack(mult_b);
    uc = unpack(addend_c);
  end

  logic        s1_spec, s1_ps, s1_sc, s1_zc;
  word_t       s1_spec_val;
  logic [52:0] s1_ma, s1_mb, s1_mc;
  exp_t        s1_ea, s1_eb, s1_ec;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_spec     <= spec_d;
      s1_spec_val <= spec_val_d;
      s1_ps       <= ps;
      s1_sc       <= sc;
      s1_zc       <= z_c;
      s1_ma       <= ua.man;
      s1_mb       <= ub.man;
      s1_mc       <= z_c ? 53'd0 : uc.man;
      s1_ea       <= ua.expo;
      s1_eb       <= ub.expo;
      s1_ec       <= uc.expo;
    end
  end

  // ---------------- stage 2: partial products, exponent compare
  exp_t pe_d, ece_d, dexp, dmag;
  logic pe_big_d;
  logic [7:0] al_sh_d;

  always_comb begin
    pe_d     = s1_ea + s1_eb - PROD_SHIFT;
    ece_d    = s1_ec - ADD_SHIFT;
    dexp     = pe_d - ece_d;
    pe_big_d = s1_zc || (dexp > 14'sd0);
    dmag     = pe_big_d ? dexp : -dexp;
    if (s1_zc) al_sh_d = 8'd0;
    else if (dmag >= 14'sd128) al_sh_d = SH_SAT;
    else al_sh_d = dmag[7:0];
  end

  logic        s2_spec, s2_ps, s2_sc, s2_pe_big;
  word_t       s2_spec_val;
  logic [51:0] s2_hh;
  logic [52:0] s2_hl, s2_lh;
  logic [53:0] s2_ll;
  logic [52:0] s2_mc;
  exp_t        s2_e;
  logic [7:0]  s2_al_sh;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s2_spec     <= s1_spec;
      s2_spec_val <= s1_spec_val;
      s2_ps       <= s1_ps;
      s2_sc       <= s1_sc;
      s2_pe_big   <= pe_big_d;
      s2_hh       <= s1_ma[52:27] * s1_mb[52:27];
      s2_hl       <= s1_ma[52:27] * s1_mb[26:0];
      s2_lh       <= s1_ma[26:0] * s1_mb[52:27];
      s2_ll       <= s1_ma[26:0] * s1_mb[26:0];
      s2_mc       <= s1_mc;
      s2_e        <= pe_big_d ? pe_d : ece_d;
      s2_al_sh    <= al_sh_d;
    end
  end

  // ---------------- stage 3: sum partial products
  logic [105:0] prod_d;
  assign prod_d = {s2_hh, 54'd0} + {52'd0, s2_ll}
                + ({53'd0, s2_hl} << 27) + ({53'd0, s2_lh} << 27);

  logic         s3_spec, s3_ps, s3_sc, s3_pe_big;
  word_t        s3_spec_val;
  logic [127:0] s3_p, s3_r;
  exp_t         s3_e;
  logic [7:0]   s3_al_sh;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s3_spec     <= s2_spec;
      s3_spec_val <= s2_spec_val;
      s3_ps       <= s2_ps;
      s3_sc       <= s2_sc;
      s3_pe_big   <= s2_pe_big;
      s3_p        <= {1'b0, prod_d, 21'd0};
      s3_r        <= {1'b0, s2_mc, 74'd0};
      s3_e        <= s2_e;
      s3_al_sh    <= s2_al_sh;
    end
  end

  // ---------------- stage 4: align smaller term with sticky
  logic [127:0] al_in, al_out;
  logic         al_sticky;

  always_comb begin
    al_in     = s3_pe_big ? s3_r : s3_p;
    al_sticky = |(al_in & ~({128{1'b1}} << s3_al_sh));
    al_out    = (al_in >> s3_al_sh) | {127'd0, al_sticky};
  end

  logic         s4_spec, s4_ps, s4_sc;
  word_t        s4_spec_val;
  logic [127:0] s4_p, s4_r;
  exp_t         s4_e;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s4_spec     <= s3_spec;
      s4_spec_val <= s3_spec_val;
      s4_ps       <= s3_ps;
      s4_sc       <= s3_sc;
      s4_p        <= s3_pe_big ? s3_p : al_out;
      s4_r        <= s3_pe_big ? al_out : s3_r;
      s4_e        <= s3_e;
    end
  end

  // ---------------- stage 5: add or subtract magnitudes
  logic [127:0] sum_d;
  logic         sign_d, p_lt_r;

  always_comb begin
    p_lt_r = s4_p < s4_r;
    if (s4_ps == s4_sc) begin
      sum_d  = s4_p + s4_r;
      sign_d = s4_ps;
    end else if (p_lt_r) begin
      sum_d  = s4_r - s4_p;
      sign_d = s4_sc;
    end else begin
      sum_d  = s4_p - s4_r;
      sign_d = s4_ps;
    end
  end

  logic         s5_spec, s5_sign, s5_zero;
  word_t        s5_spec_val;
  logic [127:0] s5_r;
  exp_t         s5_e;

  always_ff @(posedge clk) begin
    if (en[5]) begin
      s5_spec     <= s4_spec;
      s5_spec_val <= s4_spec_val;
      s5_sign     <= sign_d;
      s5_zero     <= (sum_d == '0);
      s5_r        <= sum_d;
      s5_e        <= s4_e;
    end
  end

  // ---------------- stage 6: leading zeros, normalize amount
  exp_t sh_nat, sh_min, sh_d;

  always_comb begin
    sh_nat = LEAD_POS - exp_t'(lzc128(s5_r));
    sh_min = EXP_MIN - s5_e;
    sh_d   = (sh_min > sh_nat) ? sh_min : sh_nat;
  end

  logic         s6_spec, s6_sign, s6_zero;
  word_t        s6_spec_val;
  logic [127:0] s6_r;
  exp_t         s6_e, s6_sh;

  always_ff @(posedge clk) begin
    if (en[6]) begin
      s6_spec     <= s5_spec;
      s6_spec_val <= s5_spec_val;
      s6_sign     <= s5_sign;
      s6_zero     <= s5_zero;
      s6_r        <= s5_r;
      s6_e        <= s5_e;
      s6_sh       <= sh_d;
    end
  end

  // ---------------- stage 7: shift to 53 bits, guard and sticky
  logic [52:0]  m_d;
  logic         inc_d;
  logic [7:0]   rsh;
  logic [127:0] t_sh;
  logic         rb, st, too_far;
  exp_t         lsh;

  always_comb begin
    too_far = s6_sh > 14'sd129;
    rsh     = too_far ? SH_SAT : 8'(s6_sh - 14'sd1);
    t_sh    = s6_r >> rsh;
    st      = |(s6_r & ~({128{1'b1}} << rsh));
    lsh     = -s6_sh;
    m_d     = '0;
    rb      = 1'b0;
    if (s6_sh <= 14'sd0) begin
      m_d = s6_r[52:0] << lsh[5:0];
    end else if (!too_far) begin
      m_d = t_sh[53:1];
      rb  = t_sh[0];
    end
    inc_d = rb && (st || m_d[0]);
  end

  logic        s7_spec, s7_sign, s7_zero, s7_inc;
  word_t       s7_spec_val;
  logic [52:0] s7_m;
  exp_t        s7_q;

  always_ff @(posedge clk) begin
    if (en[7]) begin
      s7_spec     <= s6_spec;
      s7_spec_val <= s6_spec_val;
      s7_sign     <= s6_sign;
      s7_zero     <= s6_zero;
      s7_inc      <= inc_d;
      s7_m        <= m_d;
      s7_q        <= s6_e + s6_sh;
    end
  end

  // ---------------- stage 8: round, pack, output register
  logic [53:0] m_rnd;
  logic [52:0] m_fin;
  exp_t        q_fin, bexp;
  word_t       res_d;

  always_comb begin
    m_rnd = {1'b0, s7_m} + {53'd0, s7_inc};
    if (m_rnd[53]) begin
      m_fin = m_rnd[53:1];
      q_fin = s7_q + 14'sd1;
    end else begin
      m_fin = m_rnd[52:0];
      q_fin = s7_q;
    end
    bexp = q_fin + EXP_BIAS;
    if (s7_spec) begin
      res_d = s7_spec_val;
    end else if (s7_zero) begin
      res_d = '0;                          // exact cancellation
    end else if (!m_fin[52]) begin
      res_d = {s7_sign, 10'd0, m_fin};     // subnormal or signed zero
    end else if (bexp >= EXP_INF) begin
      res_d = {s7_sign, INF_BITS[62:0]};
    end else begin
      res_d = {s7_sign, bexp[10:0], m_fin[51:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (en[8]) begin
      fused_result <= res_d;
    end
  end

endmodule

// ----- sim/testbench.sv -----
// Testbench for fused_multiply_add_binary64: binary64 a*b+c, one rounding to nearest even.
// Checks each result against a bit-exact predictor written here. Depends on fma64_pkg.
module testbench;
  import fma64_pkg::*;

  localparam int RANDOM_REQUESTS = 650;
  localparam int DRAIN_CYCLES    = 40;

  typedef struct {
    word_t a;
    word_t b;
    word_t c;
    logic  typed;  // expected value given in the table
    word_t want;
  } row_t;

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  in_valid = 1'b0;
  logic  in_ready;
  word_t mult_a = '0;
  word_t mult_b = '0;
  word_t addend_c = '0;
  logic  out_valid;
  logic  out_ready = 1'b0;
  word_t fused_result;

  word_t expected_sums[$];
  int    fail_count = 0;

  fused_multiply_add_binary64 DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .mult_a(mult_a), .mult_b(mult_b), .addend_c(addend_c),
    .out_valid(out_valid), .out_ready(out_ready),
    .fused_result(fused_result)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------- predictor ----------------
  function automatic int msb_index(input logic [127:0] x);
    int k;
    k = 0;
    for (int i = 0; i < 128; i++) begin
      if (x[i]) k = i;
    end
    return k;
  endfunction

  // logical right shift; collected-out bits OR into the LSB
  function automatic logic [127:0] shift_sticky(input logic [127:0] x, input int n);
    logic [127:0] k;
    if (n <= 0) return x;
    if (n >= 128) return {127'd0, |x};
    k = x >> n;
    if ((k << n) != x) k[0] = 1'b1;
    return k;
  endfunction

  function automatic void split(input word_t x, output logic [52:0] m, output int e);
    m = {1'b0, x[51:0]};
    if (x[62:52] == 11'd0) begin
      e = -1074;
      while (!m[52]) begin
        m = m << 1;
        e--;
      end
    end else begin
      m[52] = 1'b1;
      e = int'(x[62:52]) - 1075;
    end
  endfunction

  // round value r * 2^e with sign s to binary64
  function automatic word_t round_pack(input logic s, input logic [127:0] r, input int e);
    int sh, q;
    logic [127:0] rem, half, mask;
    logic [63:0] m;
    sh = msb_index(r) - 52;
    if (-1074 - e > sh) sh = -1074 - e;
    if (sh <= 0) begin
      m = r[63:0] << (-sh);
    end else if (sh > 128) begin
      m = '0;
    end else begin
      mask = (sh >= 128) ? '1 : ((128'd1 << sh) - 128'd1);
      rem  = r & mask;
      half = 128'd1 << (sh - 1);
      m    = 64'(r >> sh);
      if (rem > half || (rem == half && m[0])) m++;
    end
    q = e + sh;
    if (m == 0) return {s, 63'd0};
    if (m >= 64'h0020_0000_0000_0000) begin
      m = m >> 1;
      q++;
    end
    if (m < 64'h0010_0000_0000_0000) return {s, m[62:0]};
    if (q + 1075 >= 2047) return {s, 63'd0} | INF_BITS;
    return {s, 11'(q + 1075), m[51:0]};
  endfunction

  function automatic word_t fma_predict(input word_t a, input word_t b, input word_t c);
    logic ps, nan_a, nan_b, nan_c, inf_a, inf_b, inf_c, z_a, z_b, z_c, s;
    logic [52:0] ma, mb, mc;
    int ea, eb, ec, pe, e;
    logic [127:0] p, r;
    ps = a[63] ^ b[63];
    nan_a = &a[62:52] && |a[51:0];
    nan_b = &b[62:52] && |b[51:0];
    nan_c = &c[62:52] && |c[51:0];
    inf_a = a[62:0] == INF_BITS[62:0];
    inf_b = b[62:0] == INF_BITS[62:0];
    inf_c = c[62:0] == INF_BITS[62:0];
    z_a = a[62:0] == 0;
    z_b = b[62:0] == 0;
    z_c = c[62:0] == 0;
    if (nan_a) return a | QUIET_BIT;
    if (nan_b) return b | QUIET_BIT;
    if (nan_c) return c | QUIET_BIT;
    if (inf_a || inf_b) begin
      if (z_a || z_b || (inf_c && c[63] != ps)) return DEFAULT_NAN;
      return {ps, 63'd0} | INF_BITS;
    end
    if (inf_c) return c;
    if (z_a || z_b) return z_c ? {ps & c[63], 63'd0} : c;
    split(a, ma, ea);
    split(b, mb, eb);
    p  = (128'(ma) * 128'(mb)) << 21;
    pe = ea + eb - 21;
    if (z_c) return round_pack(ps, p, pe);
    split(c, mc, ec);
    r  = 128'(mc) << 74;
    ec = ec - 74;
    if (pe > ec) begin
      r = shift_sticky(r, pe - ec);
      e = pe;
    end else begin
      p = shift_sticky(p, ec - pe);
      e = ec;
    end
    if (ps == c[63]) begin
      r = p + r;
      s = ps;
    end else if (p < r) begin
      r = r - p;
      s = c[63];
    end else begin
      r = p - r;
      s = ps;
    end
    if (r == 0) return '0;
    return round_pack(s, r, e);
  endfunction

  // ---------------- random operands ----------------
  function automatic word_t rand_operand();
    logic [51:0] f;
    f = 52'({$urandom(), $urandom()});
    case ($urandom_range(0, 11))
      0:       return {$urandom_range(0, 1) == 1, 11'd0, f};           // subnormal
      1:       return {$urandom_range(0, 1) == 1, 63'd0};              // zero
      2:       return {$urandom_range(0, 1) == 1, 11'h7FF, 52'd0};     // infinity
      3:       return {$urandom_range(0, 1) == 1, 11'h7FF, f | 52'd1}; // NaN
      4:       return {$urandom_range(0, 1) == 1, 11'($urandom_range(1, 60)), f};
      5:       return {$urandom_range(0, 1) == 1, 11'($urandom_range(1990, 2046)), f};
      6:       return {$urandom(), $urandom()};
      default: return {$urandom_range(0, 1) == 1, 11'($urandom_range(900, 1150)), f};
    endcase
  endfunction

  // pick c near -a*b so cancellation paths get exercised
  function automatic word_t near_product(input word_t a, input word_t b);
    word_t pr;
    pr = fma_predict(a, b, '0);
    if (pr[62:52] == 11'h7FF) return rand_operand();
    pr[63] = ~pr[63];
    pr[7:0] = pr[7:0] ^ 8'($urandom_range(0, 3));
    return pr;
  endfunction

  // ---------------- sender ----------------
  task automatic send_request(input word_t a, input word_t b, input word_t c);
    mult_a   <= a;
    mult_b   <= b;
    addend_c <= c;
    in_valid <= 1'b1;
    expected_sums.push_back(fma_predict(a, b, c));
    do @(posedge clk); while (!in_ready);
  endtask

  localparam word_t ONE  = 64'h3FF0_0000_0000_0000;
  localparam word_t TWO  = 64'h4000_0000_0000_0000;
  localparam word_t MAXN = 64'h7FEF_FFFF_FFFF_FFFF;
  localparam word_t MINS = 64'h0000_0000_0000_0001;
  localparam word_t PINF = 64'h7FF0_0000_0000_0000;
  localparam word_t NINF = 64'hFFF0_0000_0000_0000;
  localparam word_t NZRO = 64'h8000_0000_0000_0000;
  localparam word_t SNAN = 64'hFFF0_0000_0000_0005;

  row_t directed_rows[$] = '{
    '{ONE, TWO, ONE, 1'b1, 64'h4008_0000_0000_0000},           // 1*2+1 = 3
    '{SNAN, ONE, ONE, 1'b1, 64'hFFF8_0000_0000_0005},          // NaN quieted
    '{ONE, 64'h7FF0_0000_0000_0123, SNAN, 1'b1, 64'h7FF8_0000_0000_0123},
    '{ONE, ONE, SNAN, 1'b1, 64'hFFF8_0000_0000_0005},
    '{PINF, 64'd0, ONE, 1'b1, DEFAULT_NAN},                    // inf * 0
    '{PINF, ONE, NINF, 1'b1, DEFAULT_NAN},                     // inf - inf
    '{PINF, NZRO | ONE, ONE, 1'b1, NINF},                      // -inf product
    '{ONE, ONE, NINF, 1'b1, NINF},                             // infinite addend
    '{64'd0, ONE, 64'h4014_0000_0000_0000, 1'b1, 64'h4014_0000_0000_0000},
    '{NZRO, ONE, NZRO, 1'b1, NZRO},                            // -0 + -0
    '{64'd0, ONE, NZRO, 1'b1, 64'd0},                          // +0 + -0
    '{ONE, ONE, NZRO | ONE, 1'b1, 64'd0},                      // exact cancel
    '{MAXN, MAXN, 64'd0, 1'b1, PINF},                          // overflow
    '{MINS, MINS, 64'd0, 1'b1, 64'd0},                         // deep underflow
    '{NZRO | MINS, MINS, NZRO, 1'b1, NZRO},
    '{MINS, ONE, MINS, 1'b1, 64'h0000_0000_0000_0002},         // subnormals
    '{MAXN, ONE, MAXN, 1'b1, PINF},
    '{64'h3FF0_0000_0000_0001, 64'h3FF0_0000_0000_0001, NZRO | ONE, 1'b0, '0},
    '{MAXN, 64'h3CA0_0000_0000_0000, MINS, 1'b0, '0},
    '{64'h0010_0000_0000_0000, 64'h3FE0_0000_0000_0000, 64'd0, 1'b0, '0},
    '{64'hFFFF_FFFF_FFFF_FFFF, ONE, ONE, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF},
    '{64'h4340_0000_0000_0000, ONE, 64'h3FF0_0000_0000_0000, 1'b0, '0}
  };

  initial begin
    word_t a, b;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table; typed rows check the predictor too
    foreach (directed_rows[i]) begin
      if (directed_rows[i].typed && fma_predict(directed_rows[i].a, directed_rows[i].b,
          directed_rows[i].c) != directed_rows[i].want) begin
        $error("table row %0d: predictor gives wrong result", i);
        fail_count++;
      end
      send_request(directed_rows[i].a, directed_rows[i].b, directed_rows[i].c);
    end
    in_valid <= 1'b0;

    // hold off until the pipeline has fully drained
    while (expected_sums.size() != 0) @(posedge clk);

    // random bursts with random gaps
    for (int n = 0; n < RANDOM_REQUESTS; ) begin
      int burst;
      burst = $urandom_range(1, 24);
      for (int k = 0; k < burst && n < RANDOM_REQUESTS; k++, n++) begin
        a = rand_operand();
        b = rand_operand();
        send_request(a, b, ($urandom_range(0, 3) == 0) ? near_product(a, b) : rand_operand());
      end
      if ($urandom_range(0, 2) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
    in_valid <= 1'b0;

    while (expected_sums.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS fused_multiply_add_binary64");
    end else begin
      $display("FAIL fused_multiply_add_binary64");
    end
    $finish;
  end

  // receiver: alternating free-running and stalling stretches
  initial begin
    int phase;
    phase = 0;
    forever begin
      @(posedge clk);
      phase++;
      if ((phase / 64) % 3 == 0) out_ready <= 1'b1;
      else out_ready <= ($urandom_range(0, 3) != 0);
    end
  end

  // compare every accepted result with the oldest pending expectation
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_sums.size() == 0) begin
        $error("fused_result: unexpected result %h", fused_result);
        fail_count++;
      end else begin
        word_t want;
        want = expected_sums.pop_front();
        if (fused_result !== want) begin
          $error("fused_result: expected %h actual %h", want, fused_result);
          fail_count++;
        end
      end
    end
  end

  initial begin
    #2000000;
    $display("FAIL fused_multiply_add_binary64");
    $finish;
  end
endmodule

// ----- sim.f -----
rtl/fma64_pkg.sv
rtl/fused_multiply_add_binary64.sv
sim/testbench.sv
